// ===== hdl/qecc_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder controller counter package
// Shared codes, limits and the transition classification table.
// ----------------------------------------------------------------------------
`default_nettype none

package qecc_pkg;

	// Classification of one pin-level change.
	typedef enum logic [1:0] {
		TRANS_STOP    = 2'd0,
		TRANS_CW      = 2'd1,
		TRANS_CCW     = 2'd2,
		TRANS_INVALID = 2'd3
	} enc_class_t;

	// Motion codes reported in a result transaction.
	localparam logic [1:0] MOTION_NONE = 2'd0;
	localparam logic [1:0] MOTION_CW   = 2'd1;
	localparam logic [1:0] MOTION_CCW  = 2'd2;

	// Controller value range.
	localparam logic [6:0] VALUE_CEIL  = 7'd127;
	localparam logic [6:0] VALUE_FLOOR = 7'd0;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACTIVE_SCENE = 2'd0;
	localparam logic [1:0] REG_VALUE_MAX    = 2'd1;
	localparam logic [1:0] REG_VALUE_MIN    = 2'd2;

	// Field widths.
	localparam int ENC_W   = 3;
	localparam int LEVEL_W = 2;
	localparam int SCENE_W = 3;
	localparam int VALUE_W = 7;

	// Classify a change from the previous A/B level to the new one.
	function automatic enc_class_t enc_classify(input logic [1:0] prev,
	                                            input logic [1:0] now);
		enc_class_t c;
		c = TRANS_INVALID;
		case (prev)
			2'd0: begin
				if (now == 2'd1) c = TRANS_CW;
				else if (now == 2'd2) c = TRANS_CCW;
			end
			2'd1, 2'd2: begin
				if (now inside {2'd0, 2'd3}) c = TRANS_STOP;
			end
			2'd3: begin
				if (now == 2'd2) c = TRANS_CW;
				else if (now == 2'd1) c = TRANS_CCW;
			end
			default: c = TRANS_INVALID;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/qecc_if.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder controller counter channels
// Valid/ready channels for pin-change events and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qecc_event_if import qecc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ENC_W-1:0]   encoder_index;
	logic [LEVEL_W-1:0] pin_pair;

	modport source(output valid, encoder_index, pin_pair, input ready);
	modport sink(input valid, encoder_index, pin_pair, output ready);
endinterface

interface qecc_result_if import qecc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ENC_W-1:0]   encoder_id;
	logic [1:0]         motion;
	logic               activity;
	logic [VALUE_W-1:0] control_value;

	modport source(output valid, encoder_id, motion, activity, control_value,
	               input ready);
	modport sink(input valid, encoder_id, motion, activity, control_value,
	             output ready);
endinterface

`default_nettype wire

// ===== hdl/quadrature_encoder_cc_counter.sv =====
// ----------------------------------------------------------------------------
// Quadrature encoder controller counter
// Pipeline: an accepted event passes the stage one registers, then the result
// register. Throughput: one event per cycle unless results stall, via the value
// RAM read-modify-write, with a bypass for back-to-back events on one entry.
// Reset: registers return to scene 0, limits 127 and 0; encoder levels and the
// per-entry valid bits clear at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_cc_counter import qecc_pkg::*; #(
	parameter int NUM_ENCODERS = 8,
	parameter int NUM_SCENES   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [VALUE_W-1:0] cfg_data,
	qecc_event_if.sink              events,
	qecc_result_if.source           results
);

	localparam int DEPTH = NUM_SCENES * NUM_ENCODERS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers.
	logic [SCENE_W-1:0] active_scene_q;
	logic [VALUE_W-1:0] value_max_q;
	logic [VALUE_W-1:0] value_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_scene_q <= '0;
			value_max_q    <= VALUE_CEIL;
			value_min_q    <= VALUE_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_SCENE: active_scene_q <= cfg_data[SCENE_W-1:0];
				REG_VALUE_MAX:    value_max_q    <= cfg_data;
				REG_VALUE_MIN:    value_min_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Handshake and pipeline control.
	logic valid_s1;
	logic out_valid_q;
	logic out_free;
	logic adv_s1;
	logic accept;

	assign out_free     = !out_valid_q || results.ready;
	assign adv_s1       = valid_s1 && out_free;
	assign events.ready = !valid_s1 || out_free;
	assign accept       = events.valid && events.ready;

	// Transition decode.
	logic       in_range;
	enc_class_t enc_class;

	qecc_decode #(
		.NUM_ENCODERS(NUM_ENCODERS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.encoder_index(events.encoder_index),
		.pin_pair     (events.pin_pair),
		.in_range     (in_range),
		.enc_class    (enc_class)
	);

	// Controller value address: scene-major, one row of encoders per scene.
	logic [AW-1:0] rd_addr;
	logic          scene_ok;

	assign rd_addr  = AW'(active_scene_q) * AW'(NUM_ENCODERS) + AW'(events.encoder_index);
	assign scene_ok = 5'(active_scene_q) < 5'(NUM_SCENES);

	// Stage one registers.
	logic [ENC_W-1:0]   enc_s1;
	enc_class_t         cls_s1;
	logic               in_range_s1;
	logic               scene_ok_s1;
	logic [AW-1:0]      addr_s1;
	logic               vld_s1;
	logic               byp_s1;
	logic [VALUE_W-1:0] byp_data_s1;

	// Write-back signals from stage one.
	logic               wr_en;
	logic [VALUE_W-1:0] wr_data;
	logic [VALUE_W-1:0] rd_data;
	logic [VALUE_W-1:0] cur_value;
	logic [DEPTH-1:0]   ent_vld_q;

	assign wr_en = adv_s1 && in_range_s1 && scene_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			enc_s1      <= events.encoder_index;
			cls_s1      <= enc_class;
			in_range_s1 <= in_range;
			scene_ok_s1 <= scene_ok;
			addr_s1     <= rd_addr;
			vld_s1      <= ent_vld_q[rd_addr];
			byp_s1      <= wr_en && (addr_s1 == rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	// Entries that have never been written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[addr_s1] <= 1'b1;
		end
	end

	qecc_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_values (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Current value with bypass of a write made in the same cycle as the read.
	always_comb begin
		if (byp_s1) cur_value = byp_data_s1;
		else if (vld_s1) cur_value = rd_data;
		else cur_value = '0;
	end

	qecc_sat u_sat (
		.enc_class(cls_s1),
		.cur      (cur_value),
		.value_max(value_max_q),
		.value_min(value_min_q),
		.nxt      (wr_data)
	);

	// Result register.
	logic [ENC_W-1:0]   encoder_id_q;
	logic [1:0]         motion_q;
	logic               activity_q;
	logic [VALUE_W-1:0] control_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			encoder_id_q <= enc_s1;
			motion_q     <= MOTION_NONE;
			activity_q   <= 1'b0;
			if (in_range_s1) begin
				case (cls_s1)
					TRANS_CW: begin
						motion_q   <= MOTION_CW;
						activity_q <= 1'b1;
					end
					TRANS_CCW: begin
						motion_q   <= MOTION_CCW;
						activity_q <= 1'b1;
					end
					TRANS_STOP: activity_q <= 1'b1;
					default:    activity_q <= 1'b0;
				endcase
			end
			control_value_q <= (in_range_s1 && scene_ok_s1) ? wr_data : '0;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.encoder_id    = encoder_id_q;
	assign results.motion        = motion_q;
	assign results.activity      = activity_q;
	assign results.control_value = control_value_q;

endmodule

`default_nettype wire

// ===== hdl/qecc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module qecc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/qecc_decode.sv =====
// ----------------------------------------------------------------------------
// Encoder transition decoder
// Holds the last A/B level of every encoder and classifies each new level.
// ----------------------------------------------------------------------------
`default_nettype none

module qecc_decode import qecc_pkg::*; #(
	parameter int NUM_ENCODERS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [ENC_W-1:0]   encoder_index,
	input  wire logic [LEVEL_W-1:0] pin_pair,
	output logic                    in_range,
	output enc_class_t              enc_class
);

	localparam int LW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

	logic [LEVEL_W-1:0] last_q [NUM_ENCODERS];
	logic [3:0]         enc_x;
	logic [LW-1:0]      idx;

	assign enc_x    = 4'(encoder_index);
	assign idx      = enc_x[LW-1:0];
	assign in_range = 5'(encoder_index) < 5'(NUM_ENCODERS);

	// Classify against the stored level of the addressed encoder.
	assign enc_class = enc_classify(last_q[idx], pin_pair);

	// Replace the stored level on every accepted in-range event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENCODERS; i++) last_q[i] <= '0;
		end else if (accept && in_range) begin
			last_q[idx] <= pin_pair;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/qecc_sat.sv =====
// ----------------------------------------------------------------------------
// Saturating controller value update
// Steps a controller value up or down by one within the configured limits.
// ----------------------------------------------------------------------------
`default_nettype none

module qecc_sat import qecc_pkg::*; (
	input  wire enc_class_t         enc_class,
	input  wire logic [VALUE_W-1:0] cur,
	input  wire logic [VALUE_W-1:0] value_max,
	input  wire logic [VALUE_W-1:0] value_min,
	output logic      [VALUE_W-1:0] nxt
);

	// Clockwise counts up below the maximum, counter-clockwise down above the minimum.
	always_comb begin
		nxt = cur;
		case (enc_class)
			TRANS_CW:  if (cur < value_max) nxt = cur + VALUE_W'(1);
			TRANS_CCW: if (cur > value_min) nxt = cur - VALUE_W'(1);
			default:   nxt = cur;
		endcase
	end

endmodule

`default_nettype wire
